### rtl/wrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrw_pkg
// Shared types and constants for the wedge recovery watchdog.
// ----------------------------------------------------------------------------
package wrw_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  RUN_MAX          = 8'hFF;
  localparam logic [7:0]  WEDGE_FLAG_MASK  = 8'h80;

  localparam logic        ENABLED_RST      = 1'b1;
  localparam logic [7:0]  WEDGE_RUN_RST    = 8'd2;
  localparam logic [31:0] MIN_UPTIME_RST   = 32'd30000;
  localparam logic [31:0] COOLDOWN_RST     = 32'd60000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
  localparam logic [7:0]  REARM_RUN_RST    = 8'd20;

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_STREAM = 2'd1,
    KIND_WEDGE  = 2'd2,
    KIND_RSVD   = 2'd3
  } line_kind_t;

  typedef enum logic [2:0] {
    REG_ENABLED      = 3'd0,
    REG_WEDGE_RUN    = 3'd1,
    REG_MIN_UPTIME   = 3'd2,
    REG_COOLDOWN     = 3'd3,
    REG_MAX_ATTEMPTS = 3'd4,
    REG_REARM_RUN    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  line_kind;
    logic        field_valid;
    logic [7:0]  field_value;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        replug_fire;
    logic        budget_rearmed;
    logic        exhausted_notice;
    logic [7:0]  attempts_used;
  } out_item_t;

  typedef struct packed {
    logic        enabled;
    logic [7:0]  wedge_run_needed;
    logic [31:0] min_uptime_ms;
    logic [31:0] cooldown_ms;
    logic [7:0]  max_attempts;
    logic [7:0]  rearm_run_needed;
  } cfg_t;

endpackage

### rtl/wedge_recovery_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wedge_recovery_watchdog
// Decides when a wedged link gets a virtual replug from decoded status
// reports.
//
// Input channel (in_valid/in_ready/in_data) carries one decoded report per
// transaction: line kind, field valid flag, field byte and uptime in ms.
// Output channel (out_valid/out_ready/out_data) returns exactly one result
// per report: replug fire, budget rearmed, exhausted notice, attempts used.
// Configuration registers sit on the cfg_ APB-style port at byte address
// 4*index; the user must write them only while no report is in flight.
// An accepted report is held in the input register; its result moves to the
// result register once that is free. Throughput: one report per cycle while
// the receiver does not stall; the state update is a single pass of counter
// and compare logic between the input and result registers. Reset clears
// the run counters, budget and fire stamp and loads the register defaults.
// When the receiver stalls, the result register holds and one more report
// waits in the input register before in_ready drops.
// ----------------------------------------------------------------------------
module wedge_recovery_watchdog (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wrw_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wrw_pkg::out_item_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wrw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wrw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wrw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import wrw_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      out_free;
  logic      step;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  wrw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wrw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  a_step_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted report produced no result");

  a_fire_not_rearm : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.replug_fire && out_item_r.budget_rearmed))
    else $error("fire and rearm in one result");

  a_fire_counts : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.replug_fire) |-> (out_item_r.attempts_used != 8'd0))
    else $error("fire without a counted attempt");

  a_rearm_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.budget_rearmed) |-> (out_item_r.attempts_used == 8'd0))
    else $error("rearm left attempts nonzero");

endmodule

### rtl/wrw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrw_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module wrw_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wrw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wrw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wrw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output wrw_pkg::cfg_t                  cfg
);
  import wrw_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLED:      cfg_nxt.enabled          = pwdata[0];
        REG_WEDGE_RUN:    cfg_nxt.wedge_run_needed = pwdata[7:0];
        REG_MIN_UPTIME:   cfg_nxt.min_uptime_ms    = pwdata[31:0];
        REG_COOLDOWN:     cfg_nxt.cooldown_ms      = pwdata[31:0];
        REG_MAX_ATTEMPTS: cfg_nxt.max_attempts     = pwdata[7:0];
        REG_REARM_RUN:    cfg_nxt.rearm_run_needed = pwdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLED:      prdata = {31'd0, cfg_r.enabled};
      REG_WEDGE_RUN:    prdata = {24'd0, cfg_r.wedge_run_needed};
      REG_MIN_UPTIME:   prdata = cfg_r.min_uptime_ms;
      REG_COOLDOWN:     prdata = cfg_r.cooldown_ms;
      REG_MAX_ATTEMPTS: prdata = {24'd0, cfg_r.max_attempts};
      REG_REARM_RUN:    prdata = {24'd0, cfg_r.rearm_run_needed};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled          <= ENABLED_RST;
      cfg_r.wedge_run_needed <= WEDGE_RUN_RST;
      cfg_r.min_uptime_ms    <= MIN_UPTIME_RST;
      cfg_r.cooldown_ms      <= COOLDOWN_RST;
      cfg_r.max_attempts     <= MAX_ATTEMPTS_RST;
      cfg_r.rearm_run_needed <= REARM_RUN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/wrw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrw_core
// Run counters, attempt budget and replug decision, one report per cycle of step.
// ----------------------------------------------------------------------------
module wrw_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  wrw_pkg::in_item_t  item,
  input  wrw_pkg::cfg_t      cfg,
  output wrw_pkg::out_item_t result
);
  import wrw_pkg::*;

  logic [7:0]  attempts_r, attempts_nxt;
  logic [7:0]  wedge_run_r, wedge_run_nxt;
  logic [7:0]  stream_run_r, stream_run_nxt;
  logic [31:0] last_fire_r, last_fire_nxt;
  logic        exh_flag_r, exh_flag_nxt;

  logic [7:0]  stream_inc;
  logic [7:0]  wedge_inc;
  logic [31:0] elapsed;
  logic        is_stream;
  logic        is_wedge;
  logic        cooling;
  logic        gate;
  logic        fire;
  logic        rearm;
  logic        notice;

  assign is_stream  = item.field_valid && (line_kind_t'(item.line_kind) == KIND_STREAM);
  assign is_wedge   = item.field_valid && (line_kind_t'(item.line_kind) == KIND_WEDGE);
  assign stream_inc = (stream_run_r != RUN_MAX) ? stream_run_r + 8'd1 : stream_run_r;
  assign wedge_inc  = (wedge_run_r != RUN_MAX) ? wedge_run_r + 8'd1 : wedge_run_r;
  assign elapsed    = item.now_ms - last_fire_r;
  assign cooling    = (last_fire_r != '0) && (elapsed < cfg.cooldown_ms);

  // wedge path gating ahead of the budget check
  assign gate = cfg.enabled && (wedge_inc >= cfg.wedge_run_needed) &&
                (item.now_ms >= cfg.min_uptime_ms) && !cooling;

  always_comb begin
    attempts_nxt   = attempts_r;
    wedge_run_nxt  = wedge_run_r;
    stream_run_nxt = stream_run_r;
    last_fire_nxt  = last_fire_r;
    exh_flag_nxt   = exh_flag_r;
    fire           = 1'b0;
    rearm          = 1'b0;
    notice         = 1'b0;
    priority if (is_stream) begin
      if (item.field_value != 8'd0) begin
        stream_run_nxt = stream_inc;
        if ((stream_inc >= cfg.rearm_run_needed) && (attempts_r != 8'd0)) begin
          attempts_nxt = 8'd0;
          exh_flag_nxt = 1'b0;
          rearm        = 1'b1;
        end
      end else begin
        stream_run_nxt = 8'd0;
      end
    end else if (is_wedge) begin
      if ((item.field_value & WEDGE_FLAG_MASK) == 8'd0) begin
        wedge_run_nxt = 8'd0;
      end else begin
        wedge_run_nxt = wedge_inc;
        if (gate) begin
          if (attempts_r >= cfg.max_attempts) begin
            if (!exh_flag_r) begin
              exh_flag_nxt = 1'b1;
              notice       = 1'b1;
            end
          end else begin
            wedge_run_nxt = 8'd0;
            attempts_nxt  = attempts_r + 8'd1;
            last_fire_nxt = item.now_ms;
            fire          = 1'b1;
          end
        end
      end
    end else begin
      attempts_nxt = attempts_r;
    end
  end

  assign result.replug_fire      = fire;
  assign result.budget_rearmed   = rearm;
  assign result.exhausted_notice = notice;
  assign result.attempts_used    = attempts_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempts_r   <= '0;
      wedge_run_r  <= '0;
      stream_run_r <= '0;
      last_fire_r  <= '0;
      exh_flag_r   <= 1'b0;
    end else if (step) begin
      attempts_r   <= attempts_nxt;
      wedge_run_r  <= wedge_run_nxt;
      stream_run_r <= stream_run_nxt;
      last_fire_r  <= last_fire_nxt;
      exh_flag_r   <= exh_flag_nxt;
    end
  end

endmodule
